@@ design/pbmh_pkg.sv @@
// Shared types and constants of the polar max-height grid unit.
// Holds the command codes, controller states, control structs and the CORDIC angle table.
// No dependencies.
package pbmh_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_code_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SQUARE,
		ST_RANGE,
		ST_TARGET,
		ST_ITER,
		ST_SCALE,
		ST_SECTOR,
		ST_INDEX,
		ST_FETCH,
		ST_UPDATE,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Register indexes on the configuration port.
	localparam logic REG_MAX_RADIUS    = 1'b0;
	localparam logic REG_HEIGHT_OFFSET = 1'b1;

	localparam logic [22:0] MAX_RADIUS_RST    = 23'd81920;
	localparam logic [23:0] HEIGHT_OFFSET_RST = 24'd2048;

	localparam int CORDIC_STEPS = 24;

	typedef struct packed {
		logic in_ready;
		logic load_in;
		logic square;
		logic range_chk;
		logic target;
		logic iter;
		logic scale;
		logic sector;
		logic index;
		logic update;
		logic sweep;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       kept;
		logic       iter_done;
		logic       sweep_done;
		logic       out_free;
	} ctrl_sts_t;

	// Step angles of the CORDIC, 2^32 units per full turn.
	function automatic logic [31:0] step_angle(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:    a = 32'd536870912;
			5'd1:    a = 32'd316933406;
			5'd2:    a = 32'd167458907;
			5'd3:    a = 32'd85004756;
			5'd4:    a = 32'd42667331;
			5'd5:    a = 32'd21354465;
			5'd6:    a = 32'd10679838;
			5'd7:    a = 32'd5340245;
			5'd8:    a = 32'd2670163;
			5'd9:    a = 32'd1335087;
			5'd10:   a = 32'd667544;
			5'd11:   a = 32'd333772;
			5'd12:   a = 32'd166886;
			5'd13:   a = 32'd83443;
			5'd14:   a = 32'd41721;
			5'd15:   a = 32'd20860;
			5'd16:   a = 32'd10430;
			5'd17:   a = 32'd5215;
			5'd18:   a = 32'd2607;
			5'd19:   a = 32'd1303;
			5'd20:   a = 32'd651;
			5'd21:   a = 32'd325;
			5'd22:   a = 32'd162;
			5'd23:   a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

@@ design/pbmh_ctrl.sv @@
// Controller state machine of the polar max-height grid unit.
// Sequences the datapath through its steps; depends on pbmh_pkg.
module pbmh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pbmh_pkg::ctrl_sts_t sts,
	output pbmh_pkg::ctrl_cmd_t cmd
);

	pbmh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbmh_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			pbmh_pkg::ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = pbmh_pkg::ST_IDLE;
				end
			end
			pbmh_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = pbmh_pkg::ST_DECODE;
				end
			end
			pbmh_pkg::ST_DECODE: begin
				case (sts.cmd)
					pbmh_pkg::CMD_CLEAR: state_d = pbmh_pkg::ST_CLEAR;
					pbmh_pkg::CMD_ADD:   state_d = pbmh_pkg::ST_SQUARE;
					pbmh_pkg::CMD_READ:  state_d = pbmh_pkg::ST_INDEX;
					default:             state_d = pbmh_pkg::ST_DONE;
				endcase
			end
			pbmh_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = pbmh_pkg::ST_RANGE;
			end
			pbmh_pkg::ST_RANGE: begin
				cmd.range_chk = 1'b1;
				state_d       = pbmh_pkg::ST_TARGET;
			end
			pbmh_pkg::ST_TARGET: begin
				if (sts.kept) begin
					cmd.target = 1'b1;
					state_d    = pbmh_pkg::ST_ITER;
				end else begin
					state_d = pbmh_pkg::ST_DONE;
				end
			end
			pbmh_pkg::ST_ITER: begin
				cmd.iter = 1'b1;
				if (sts.iter_done) begin
					state_d = pbmh_pkg::ST_SCALE;
				end
			end
			pbmh_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = pbmh_pkg::ST_SECTOR;
			end
			pbmh_pkg::ST_SECTOR: begin
				cmd.sector = 1'b1;
				state_d    = pbmh_pkg::ST_INDEX;
			end
			pbmh_pkg::ST_INDEX: begin
				cmd.index = 1'b1;
				state_d   = pbmh_pkg::ST_FETCH;
			end
			pbmh_pkg::ST_FETCH: begin
				state_d = pbmh_pkg::ST_UPDATE;
			end
			pbmh_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = pbmh_pkg::ST_DONE;
			end
			pbmh_pkg::ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = pbmh_pkg::ST_DONE;
				end
			end
			pbmh_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = pbmh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbmh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/pbmh_dpath.sv @@
// Datapath of the polar max-height grid unit: range, CORDIC azimuth, ring search,
// cell memory and result register. Depends on pbmh_pkg.
module pbmh_dpath #(
	parameter int NUM_RINGS   = 20,
	parameter int NUM_SECTORS = 60
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic [87:0]         in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [39:0]         out_data,
	input  pbmh_pkg::ctrl_cmd_t cmd,
	output pbmh_pkg::ctrl_sts_t sts
);

	localparam int CELLS = NUM_RINGS * NUM_SECTORS;
	localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = $clog2(NUM_RINGS + 1);
	localparam int SW    = $clog2(NUM_SECTORS + 1);
	localparam int R2W   = 2 * RW;
	localparam int TW    = 46 + R2W;
	localparam int PW    = 33 + SW;
	localparam logic [R2W-1:0] RING_SQ   = R2W'(NUM_RINGS * NUM_RINGS);
	localparam logic [32:0]    HALF_TURN = 33'h0_8000_0000;
	localparam logic [32:0]    FULL_TURN = 33'h1_0000_0000;
	localparam logic [33:0]    QTR_TURN  = 34'h0_4000_0000;

	// Configuration registers.
	logic        [22:0] max_radius_q;
	logic signed [23:0] height_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_radius_q    <= pbmh_pkg::MAX_RADIUS_RST;
			height_offset_q <= pbmh_pkg::HEIGHT_OFFSET_RST;
		end else if (cfg_valid) begin
			if (cfg_index == pbmh_pkg::REG_MAX_RADIUS) begin
				max_radius_q <= cfg_data[22:0];
			end else begin
				height_offset_q <= cfg_data;
			end
		end
	end

	// Latched item.
	logic        [1:0]  cmd_q;
	logic signed [23:0] x_q, y_q, z_q;
	logic        [4:0]  rr_q;
	logic        [5:0]  rs_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= in_data[1:0];
			x_q   <= in_data[25:2];
			y_q   <= in_data[49:26];
			z_q   <= in_data[73:50];
			rr_q  <= in_data[78:74];
			rs_q  <= in_data[84:79];
		end
	end

	logic [23:0] ax, ay;
	assign ax = x_q[23] ? (~x_q + 24'd1) : x_q;
	assign ay = y_q[23] ? (~y_q + 24'd1) : y_q;

	// Squares and range check.
	logic [46:0] ax2_q, ay2_q;
	logic [45:0] rm2_q, r2_q;
	logic [47:0] r2_sum;
	logic        kept_q;

	assign r2_sum = {1'b0, ax2_q} + {1'b0, ay2_q};

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			ax2_q <= 47'(ax * ax);
			ay2_q <= 47'(ay * ay);
			rm2_q <= max_radius_q * max_radius_q;
		end
		if (cmd.range_chk) begin
			kept_q <= (r2_sum <= {2'b00, rm2_q});
			r2_q   <= r2_sum[45:0];
		end
	end

	// Ring search: (k*rm)^2 walks up by odd multiples of rm^2.
	logic [TW-1:0] target_q, sq_q, d_q, rm2x2;
	logic [RW-1:0] ring_q;
	logic          ring_done_q;

	assign rm2x2 = TW'({rm2_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_done_q <= 1'b0;
		end else if (cmd.target) begin
			ring_done_q <= 1'b0;
		end else if (cmd.iter && !ring_done_q) begin
			if (ring_q == RW'(NUM_RINGS) || sq_q >= target_q) begin
				ring_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.target) begin
			target_q <= TW'(r2_q * RING_SQ);
			ring_q   <= RW'(1);
			sq_q     <= TW'(rm2_q);
			d_q      <= TW'(rm2_q);
		end else if (cmd.iter && !ring_done_q) begin
			if (!(ring_q == RW'(NUM_RINGS) || sq_q >= target_q)) begin
				ring_q <= ring_q + RW'(1);
				d_q    <= d_q + rm2x2;
				sq_q   <= sq_q + d_q + rm2x2;
			end
		end
	end

	// CORDIC vectoring, one step a cycle.
	logic signed [33:0] cx_q, cy_q, ang_q, dx, dy, step;
	logic        [4:0]  cnt_q;
	logic               cordic_done;

	assign cordic_done = (cnt_q == 5'(pbmh_pkg::CORDIC_STEPS));
	assign dx   = cx_q >>> cnt_q;
	assign dy   = cy_q >>> cnt_q;
	assign step = $signed({2'b00, pbmh_pkg::step_angle(cnt_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.target) begin
			cnt_q <= '0;
		end else if (cmd.iter && !cordic_done) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			cx_q  <= $signed({2'b00, ax, 8'h00});
			cy_q  <= $signed({2'b00, ay, 8'h00});
			ang_q <= '0;
		end else if (cmd.iter && !cordic_done) begin
			if (!cy_q[33]) begin
				cx_q  <= cx_q + dy;
				cy_q  <= cy_q - dx;
				ang_q <= ang_q + step;
			end else begin
				cx_q  <= cx_q - dy;
				cy_q  <= cy_q + dx;
				ang_q <= ang_q - step;
			end
		end
	end

	// Full-turn angle and sector.
	logic [30:0]   phi;
	logic [32:0]   ang;
	logic [PW-1:0] prod_q, prod_rnd;
	logic [SW:0]   sec_raw;
	logic [SW-1:0] sec_q;

	always_comb begin
		if (ang_q[33]) begin
			phi = '0;
		end else if (ang_q > $signed(QTR_TURN)) begin
			phi = 31'h4000_0000;
		end else begin
			phi = ang_q[30:0];
		end
		if (x_q == 24'sd0 && y_q == 24'sd0) begin
			ang = '0;
		end else if (!x_q[23] && !y_q[23]) begin
			ang = {2'b00, phi};
		end else if (x_q[23] && !y_q[23]) begin
			ang = HALF_TURN - {2'b00, phi};
		end else if (x_q[23]) begin
			ang = HALF_TURN + {2'b00, phi};
		end else begin
			ang = FULL_TURN - {2'b00, phi};
		end
	end

	assign prod_rnd = prod_q + PW'(32'hFFFF_FFFF);
	assign sec_raw  = prod_rnd[PW-1:32];

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			prod_q <= PW'(ang * NUM_SECTORS);
		end
		if (cmd.sector) begin
			if (sec_raw == '0) begin
				sec_q <= SW'(1);
			end else if (sec_raw > (SW+1)'(NUM_SECTORS)) begin
				sec_q <= SW'(NUM_SECTORS);
			end else begin
				sec_q <= sec_raw[SW-1:0];
			end
		end
	end

	// Cell memory: {valid, height}.
	logic [25:0]   mem_q [CELLS];
	logic [25:0]   rd_q;
	logic [IW-1:0] idx_q, clr_cnt_q, wr_addr;
	logic          inrange_q, wr_en, wr_upd;
	logic [25:0]   wr_data;
	logic signed [24:0] h;

	assign h = 25'(z_q) + 25'(height_offset_q);

	always_ff @(posedge clk) begin
		if (cmd.index) begin
			if (cmd_q == pbmh_pkg::CMD_ADD) begin
				idx_q <= IW'(32'(ring_q - RW'(1)) * NUM_SECTORS + 32'(sec_q - SW'(1)));
			end else begin
				idx_q <= IW'(32'(rr_q) * NUM_SECTORS + 32'(rs_q));
			end
			inrange_q <= (32'(rr_q) < NUM_RINGS) && (32'(rs_q) < NUM_SECTORS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.sweep && clr_cnt_q != IW'(CELLS - 1)) begin
			clr_cnt_q <= clr_cnt_q + IW'(1);
		end else begin
			clr_cnt_q <= '0;
		end
	end

	assign wr_upd  = cmd.update && (cmd_q == pbmh_pkg::CMD_ADD)
		&& (!rd_q[25] || h > $signed(rd_q[24:0]));
	assign wr_en   = cmd.sweep || wr_upd;
	assign wr_addr = cmd.sweep ? clr_cnt_q : idx_q;
	assign wr_data = cmd.sweep ? 26'd0 : {1'b1, h};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[idx_q];
	end

	// Result fields and output register.
	logic [23:0] res_h_q;
	logic        res_filled_q, res_kept_q;
	logic [4:0]  res_ring_q;
	logic [5:0]  res_sec_q;
	logic [7:0]  ring_m1;
	logic [8:0]  sec_m1;
	logic [23:0] h_sat;
	logic signed [24:0] rd_h;

	assign ring_m1 = 8'(ring_q - RW'(1));
	assign sec_m1  = 9'(sec_q - SW'(1));
	assign rd_h    = $signed(rd_q[24:0]);

	always_comb begin
		if (rd_h > 25'sd8388607) begin
			h_sat = 24'h7F_FFFF;
		end else if (rd_h < -25'sd8388608) begin
			h_sat = 24'h80_0000;
		end else begin
			h_sat = rd_h[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_h_q      <= '0;
			res_filled_q <= 1'b0;
			res_kept_q   <= 1'b0;
			res_ring_q   <= '0;
			res_sec_q    <= '0;
		end else if (cmd.update) begin
			if (cmd_q == pbmh_pkg::CMD_ADD) begin
				res_kept_q <= 1'b1;
				res_ring_q <= ring_m1[4:0];
				res_sec_q  <= sec_m1[5:0];
			end else if (inrange_q && rd_q[25]) begin
				res_h_q      <= h_sat;
				res_filled_q <= 1'b1;
			end
		end
	end

	logic        out_valid_q;
	logic [39:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {3'b000, res_sec_q, res_ring_q, res_kept_q, res_filled_q, res_h_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sts.cmd        = cmd_q;
	assign sts.kept       = kept_q;
	assign sts.iter_done  = cordic_done && ring_done_q;
	assign sts.sweep_done = (clr_cnt_q == IW'(CELLS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

@@ design/polar_bin_max_height_grid_unit.sv @@
// Polar max-height grid unit. An add runs the range check, then the 24-step CORDIC with the ring
// search beside it, then the sector and the cell update. A read fetches one cell; a clear sweeps
// the cell memory one entry a cycle. One item is in work at a time; a finished result waits in
// the output register. Reset is asynchronous; after it a clearing pass over every cell runs
// before the first item is taken. Configuration writes are taken at any time.
module polar_bin_max_height_grid_unit #(
	parameter int NUM_RINGS   = 20,
	parameter int NUM_SECTORS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: index 0 max_radius, index 1 height_offset.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	// Input items. tdata from bit 0: command[1:0], point_x[25:2], point_y[49:26],
	// point_z[73:50], read_ring[78:74], read_sector[84:79], zero fill.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,
	// Result items. tdata from bit 0: cell_height[23:0], cell_filled[24], point_kept[25],
	// bin_ring[30:26], bin_sector[36:31], zero fill.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata
);

	pbmh_pkg::ctrl_cmd_t cmd;
	pbmh_pkg::ctrl_sts_t sts;

	// The host writes registers only while idle; the block does not enforce this.
	assign cfg_ready = 1'b1;
	assign s_tready  = cmd.in_ready;

	pbmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbmh_dpath #(
		.NUM_RINGS   (NUM_RINGS),
		.NUM_SECTORS (NUM_SECTORS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Only one item is in work: the cycle after an accept never accepts.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

	// No item is taken while the clearing pass runs.
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !s_tready)
		else $error("input ready during clearing pass");

	// An add result never reports a filled cell.
	a_kept_not_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[25]) |-> !m_tdata[24])
		else $error("add result carries read fields");

endmodule
